@@ hw/rtl/pdc_pkg.sv @@
// ----------------------------------------------------------------------------
// pdc_pkg
// Widths, register codes, stage struct and integral saturation for the
// PID duty controller.
// ----------------------------------------------------------------------------
package pdc_pkg;

	localparam int MEAS_W       = 24;
	localparam int ERR_W        = 25;
	localparam int DELTA_W      = 26;
	localparam int SUM_W        = 32;
	localparam int GAIN_W       = 16;
	localparam int ACC_W        = 50;
	localparam int MAG_W        = 27;
	localparam int QUOT_W       = 14;
	localparam int DUTY_W       = 8;
	localparam int DUTYC_W      = 15;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 24;
	localparam int GAIN_SCALE   = 10000;
	localparam int MAX_DUTY_DEF = 100;

	// reciprocal of the gain scale, exact for magnitudes below 2**MAG_W
	localparam int RECIP_SHIFT = 41;
	localparam int RECIP_W     = 28;
	localparam longint unsigned RECIP =
		((64'd1 << RECIP_SHIFT) + 64'(GAIN_SCALE - 1)) / 64'(GAIN_SCALE);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET = 2'd0,
		CFG_GAIN_P = 2'd1,
		CFG_GAIN_I = 2'd2,
		CFG_GAIN_D = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic             valid;
		logic             over;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} pdc_s2_t;

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
		logic signed [SUM_W-1:0] r;
		if (v[SUM_W] != v[SUM_W-1]) begin
			r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			r = v[SUM_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/pdc_if.sv @@
// ----------------------------------------------------------------------------
// pdc_if
// Valid/ready channels for measured samples and duty results.
// ----------------------------------------------------------------------------
interface pdc_meas_if import pdc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [MEAS_W-1:0] measured_value;

	modport source (output valid, output measured_value, input ready);
	modport sink   (input valid, input measured_value, output ready);
endinterface

interface pdc_duty_if import pdc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DUTY_W-1:0] duty_out;
	logic                     overload_flag;

	modport source (output valid, output duty_out, output overload_flag, input ready);
	modport sink   (input valid, input duty_out, input overload_flag, output ready);
endinterface

@@ hw/rtl/pdc_core.sv @@
// ----------------------------------------------------------------------------
// pdc_core
// Error, saturating integral with anti-windup, weighted sum and overload
// test. Holds the controller state and the second stage register.
// ----------------------------------------------------------------------------
module pdc_core import pdc_pkg::*; #(
	parameter int MAX_DUTY = MAX_DUTY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  logic                     valid_s1,
	input  logic signed [MEAS_W-1:0] meas_s1,
	input  logic signed [MEAS_W-1:0] target,
	input  logic        [GAIN_W-1:0] gain_p,
	input  logic        [GAIN_W-1:0] gain_i,
	input  logic        [GAIN_W-1:0] gain_d,
	output pdc_s2_t                  s2
);

	localparam logic signed [ACC_W-1:0] THR = ACC_W'((MAX_DUTY + 1) * GAIN_SCALE);

	logic signed [SUM_W-1:0]        error_sum_q;
	logic signed [ERR_W-1:0]        last_err_q;
	pdc_s2_t                        s2_q;

	logic signed [ERR_W-1:0]        err;
	logic signed [DELTA_W-1:0]      delta;
	logic signed [SUM_W-1:0]        sum_add;
	logic signed [SUM_W-1:0]        sum_back;
	logic signed [SUM_W-1:0]        sum_next;
	logic signed [ERR_W+GAIN_W:0]   p_prod;
	logic signed [SUM_W+GAIN_W:0]   i_prod;
	logic signed [DELTA_W+GAIN_W:0] d_prod;
	logic signed [ACC_W-1:0]        acc;
	logic signed [ACC_W-1:0]        acc_abs;
	logic                           over;

	always_comb begin
		err      = {target[MEAS_W-1], target} - {meas_s1[MEAS_W-1], meas_s1};
		delta    = {last_err_q[ERR_W-1], last_err_q} - {err[ERR_W-1], err};
		sum_add  = sat_sum({error_sum_q[SUM_W-1], error_sum_q}
			+ {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err});
		p_prod   = err * $signed({1'b0, gain_p});
		i_prod   = sum_add * $signed({1'b0, gain_i});
		d_prod   = delta * $signed({1'b0, gain_d});
		acc      = ACC_W'(p_prod) + ACC_W'(i_prod) + ACC_W'(d_prod);
		over     = (acc >= THR) || (acc <= -THR);
		sum_back = sat_sum({sum_add[SUM_W-1], sum_add}
			- {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err});
		sum_next = over ? sum_back : sum_add;
		acc_abs  = acc[ACC_W-1] ? -acc : acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			last_err_q  <= '0;
			s2_q        <= '0;
		end else if (advance) begin
			s2_q.valid <= valid_s1;
			s2_q.over  <= over;
			s2_q.neg   <= acc[ACC_W-1];
			s2_q.mag   <= acc_abs[MAG_W-1:0];
			if (valid_s1) begin
				error_sum_q <= sum_next;
				last_err_q  <= err;
			end
		end
	end

	assign s2 = s2_q;

endmodule

@@ hw/rtl/pdc_scale.sv @@
// ----------------------------------------------------------------------------
// pdc_scale
// Divides the weighted sum magnitude by the gain scale through a
// reciprocal multiply, clamps on overload and holds the result register.
// ----------------------------------------------------------------------------
module pdc_scale import pdc_pkg::*; #(
	parameter int MAX_DUTY = MAX_DUTY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  pdc_s2_t                  s2,
	output logic                     valid,
	output logic signed [DUTY_W-1:0] duty,
	output logic                     over
);

	localparam logic signed [DUTYC_W-1:0] DUTY_MAX = DUTYC_W'(MAX_DUTY);

	logic                         valid_q;
	logic signed [DUTY_W-1:0]     duty_q;
	logic                         over_q;

	logic [MAG_W+RECIP_W-1:0]     prod;
	logic [QUOT_W-1:0]            quot;
	logic signed [DUTYC_W-1:0]    duty_c;

	always_comb begin
		prod = (MAG_W+RECIP_W)'(s2.mag) * (MAG_W+RECIP_W)'(RECIP);
		quot = prod[RECIP_SHIFT +: QUOT_W];
		if (s2.over) begin
			duty_c = s2.neg ? -DUTY_MAX : DUTY_MAX;
		end else begin
			duty_c = s2.neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			duty_q  <= '0;
			over_q  <= 1'b0;
		end else if (advance) begin
			valid_q <= s2.valid;
			duty_q  <= duty_c[DUTY_W-1:0];
			over_q  <= s2.over;
		end
	end

	assign valid = valid_q;
	assign duty  = duty_q;
	assign over  = over_q;

endmodule

@@ hw/rtl/pid_duty_controller.sv @@
// ----------------------------------------------------------------------------
// pid_duty_controller
// Path from sample accept to result valid: the input register, then the
// PID update into the second stage register, then the scaling and clamp
// into the result register. One item per cycle unless the result stalls;
// the integral update feeds back on its own register. A stalled result holds
// all three stages. Reset clears registers, integral and last error to zero.
// ----------------------------------------------------------------------------
module pid_duty_controller import pdc_pkg::*; #(
	parameter int MAX_DUTY = MAX_DUTY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	pdc_meas_if.sink              sample,
	pdc_duty_if.source            result
);

	localparam logic [DUTY_W-1:0] DUTY_POS = DUTY_W'(MAX_DUTY);
	localparam logic [DUTY_W-1:0] DUTY_NEG = DUTY_W'(0 - MAX_DUTY);
	localparam logic [MAG_W-1:0]  THR_MAG  = MAG_W'((MAX_DUTY + 1) * GAIN_SCALE);

	logic signed [MEAS_W-1:0] target_q;
	logic        [GAIN_W-1:0] gain_p_q;
	logic        [GAIN_W-1:0] gain_i_q;
	logic        [GAIN_W-1:0] gain_d_q;

	logic                     valid_s1;
	logic signed [MEAS_W-1:0] meas_s1;
	logic                     advance;
	pdc_s2_t                  s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TARGET: target_q <= cfg_wdata;
				CFG_GAIN_P: gain_p_q <= cfg_wdata[GAIN_W-1:0];
				CFG_GAIN_I: gain_i_q <= cfg_wdata[GAIN_W-1:0];
				CFG_GAIN_D: gain_d_q <= cfg_wdata[GAIN_W-1:0];
			endcase
		end
	end

	assign advance      = !result.valid || result.ready;
	assign sample.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			meas_s1  <= '0;
		end else if (advance) begin
			valid_s1 <= sample.valid;
			meas_s1  <= sample.measured_value;
		end
	end

	pdc_core #(.MAX_DUTY(MAX_DUTY)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.meas_s1  (meas_s1),
		.target   (target_q),
		.gain_p   (gain_p_q),
		.gain_i   (gain_i_q),
		.gain_d   (gain_d_q),
		.s2       (s2)
	);

	pdc_scale #(.MAX_DUTY(MAX_DUTY)) u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.s2      (s2),
		.valid   (result.valid),
		.duty    (result.duty_out),
		.over    (result.overload_flag)
	);

	a_over_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.overload_flag |->
			(result.duty_out == DUTY_POS || result.duty_out == DUTY_NEG))
		else $error("overload result not clamped");

	a_free_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> sample.ready)
		else $error("sample blocked with empty result register");

	a_mag_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		s2.valid && !s2.over |-> s2.mag < THR_MAG)
		else $error("in-range magnitude beyond overload threshold");

endmodule
